>>> design/hsv_saturation_boost_macros.svh
// assertion macros for the saturation boost block
`ifndef HSV_SATURATION_BOOST_MACROS_SVH
`define HSV_SATURATION_BOOST_MACROS_SVH
`ifndef SYNTHESIS
`define HSB_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define HSB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define HSB_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define HSB_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> design/hsb_pkg.sv
// shared constants, types and division helpers for the saturation boost block
package hsb_pkg;
    localparam int unsigned PixW    = 8;
    localparam int unsigned GainW   = 10;
    localparam int unsigned GainRst = 384;
    localparam int unsigned QuoW    = 9;  // low quotient bits kept by the divider
    localparam int unsigned NumW    = 18; // 17 bit numerator with one leading zero
    localparam int unsigned DivSteps = 3;

    // one step group of restoring division: numerator bits enter msb first
    typedef struct packed {
        logic [16:0]     rem;
        logic [NumW-1:0] num;
        logic [QuoW-1:0] quo;
        logic [7:0]      den;
    } t_div;

    // perform three restoring division steps
    function automatic t_div div_steps(input t_div a);
        t_div   o;
        logic [17:0] trial;
        o = a;
        for (int k = 0; k < DivSteps; k++) begin
            trial = {o.rem, o.num[NumW-1]};
            o.num = {o.num[NumW-2:0], 1'b0};
            if (trial >= {10'd0, o.den}) begin
                o.rem = 17'(trial - {10'd0, o.den});
                o.quo = {o.quo[QuoW-2:0], 1'b1};
            end else begin
                o.rem = trial[16:0];
                o.quo = {o.quo[QuoW-2:0], 1'b0};
            end
        end
        return o;
    endfunction
endpackage

>>> design/hsv_saturation_boost.sv
// top level of the saturation boost block
// One BGR pixel word enters at every clock edge where start is high; busy is tied low, so
// pixels can follow back to back. Each result is on o_done for one cycle, after its pixel
// has passed through 13 register stages: max/min, numerators, six stages of the hue and
// saturation dividers (three quotient bits a stage), gain and hue weights, weight sums,
// products, reciprocal multiply by 1/15300 and its correction.
// The receiver cannot stall. o_cfg_ready is always high; write the gain only while no
// pixel is in flight.
`include "hsv_saturation_boost_macros.svh"
module hsv_saturation_boost #(
    parameter int unsigned GainReset = hsb_pkg::GainRst
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [7:0] i_blue_in,
    input  logic [7:0] i_green_in,
    input  logic [7:0] i_red_in,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [9:0] i_cfg_data,
    output logic       o_done,
    output logic [7:0] o_blue_out,
    output logic [7:0] o_green_out,
    output logic [7:0] o_red_out
);
    logic [9:0] r_gain;
    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_gain <= 10'(GainReset);
        else if (i_cfg_valid && o_cfg_ready) r_gain <= i_cfg_data;
    end

    // stage 1: max, min, sector
    logic       r_p1_v;
    logic [7:0] r_p1_max, r_p1_d;
    logic [1:0] r_p1_sec;      // 0 red, 1 green, 2 blue
    logic       r_p1_neg;
    logic [7:0] r_p1_diff;     // |numerator difference|
    always_ff @(posedge i_clk) begin
        logic [7:0] mx, mn;
        mx = i_blue_in; if (i_green_in > mx) mx = i_green_in; if (i_red_in > mx) mx = i_red_in;
        mn = i_blue_in; if (i_green_in < mn) mn = i_green_in; if (i_red_in < mn) mn = i_red_in;
        r_p1_max <= mx;
        r_p1_d   <= 8'(mx - mn);
        r_p1_neg <= 1'b0;
        if (mx == i_red_in) begin
            r_p1_sec <= 2'd0;
            if (i_green_in >= i_blue_in) r_p1_diff <= 8'(i_green_in - i_blue_in);
            else begin r_p1_diff <= 8'(i_blue_in - i_green_in); r_p1_neg <= 1'b1; end
        end else if (mx == i_green_in) begin
            r_p1_sec <= 2'd1;
            if (i_blue_in >= i_red_in) r_p1_diff <= 8'(i_blue_in - i_red_in);
            else begin r_p1_diff <= 8'(i_red_in - i_blue_in); r_p1_neg <= 1'b1; end
        end else begin
            r_p1_sec <= 2'd2;
            if (i_red_in >= i_green_in) r_p1_diff <= 8'(i_red_in - i_green_in);
            else begin r_p1_diff <= 8'(i_green_in - i_red_in); r_p1_neg <= 1'b1; end
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_p1_v <= 1'b0; else r_p1_v <= start;
    end

    // stage 2: numerators
    logic        r_p2_v;
    logic [16:0] r_p2_snum, r_p2_hnum;
    logic [7:0]  r_p2_max, r_p2_d;
    always_ff @(posedge i_clk) begin
        logic [16:0] base, off;
        r_p2_snum <= 17'(r_p1_d) * 17'd255;
        off = 17'(r_p1_diff) * 17'd30;
        case (r_p1_sec)
            2'd0:    base = r_p1_neg ? 17'(r_p1_d) * 17'd180 : 17'd0;
            2'd1:    base = 17'(r_p1_d) * 17'd60;
            default: base = 17'(r_p1_d) * 17'd120;
        endcase
        r_p2_hnum <= r_p1_neg ? 17'(base - off) : 17'(base + off);
        r_p2_max  <= r_p1_max;
        r_p2_d    <= r_p1_d;
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_p2_v <= 1'b0; else r_p2_v <= r_p1_v;
    end

    // saturation and hue dividers run in lockstep; the tag carries the divisor
    logic                     sat_vld, hue_vld;
    logic [hsb_pkg::QuoW-1:0] sat_quo, hue_quo;
    logic [7:0]               sat_max, hue_d;

    hsb_divider #(
        .TagW(hsb_pkg::PixW)
    ) u_sat_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(r_p2_v),
        .i_num(r_p2_snum), .i_den(r_p2_max), .i_tag(r_p2_max),
        .o_valid(sat_vld), .o_quo(sat_quo), .o_tag(sat_max)
    );

    hsb_divider #(
        .TagW(hsb_pkg::PixW)
    ) u_hue_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(r_p2_v),
        .i_num(r_p2_hnum), .i_den(r_p2_d), .i_tag(r_p2_d),
        .o_valid(hue_vld), .o_quo(hue_quo), .o_tag(hue_d)
    );

    // stage a: saturation gain and hue weights
    logic        r_pa_v;
    logic [7:0]  r_pa_s2, r_pa_v8;
    logic [5:0]  r_pa_fr, r_pa_fg, r_pa_fb;
    always_ff @(posedge i_clk) begin
        logic [7:0]  s, h;
        logic [17:0] p;
        logic [8:0]  hd, rem;
        logic [5:0]  fr;
        s = (sat_max == 8'd0) ? 8'd0 : sat_quo[7:0];
        h = (hue_d == 8'd0) ? 8'd0 : hue_quo[7:0];
        p = 18'(s) * 18'(r_gain);
        r_pa_s2 <= (p[17:8] > 10'd255) ? 8'd255 : p[15:8];
        hd = {h, 1'b0};
        if (hd >= 9'd240) rem = 9'(hd - 9'd240);
        else if (hd >= 9'd120) rem = 9'(hd - 9'd120);
        else rem = hd;
        fr = (rem < 9'd60) ? rem[5:0] : 6'(9'd120 - rem);
        if (hd < 9'd60)       begin r_pa_fr <= 6'd60; r_pa_fg <= fr;    r_pa_fb <= 6'd0;  end
        else if (hd < 9'd120) begin r_pa_fr <= fr;    r_pa_fg <= 6'd60; r_pa_fb <= 6'd0;  end
        else if (hd < 9'd180) begin r_pa_fr <= 6'd0;  r_pa_fg <= 6'd60; r_pa_fb <= fr;    end
        else if (hd < 9'd240) begin r_pa_fr <= 6'd0;  r_pa_fg <= fr;    r_pa_fb <= 6'd60; end
        else if (hd < 9'd300) begin r_pa_fr <= fr;    r_pa_fg <= 6'd0;  r_pa_fb <= 6'd60; end
        else                  begin r_pa_fr <= 6'd60; r_pa_fg <= 6'd0;  r_pa_fb <= fr;    end
        r_pa_v8 <= sat_max;
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_pa_v <= 1'b0; else r_pa_v <= sat_vld;
    end

    // stage b: per-channel weight sum 60*(255-s2)+s2*f, up to 15300
    logic        r_pb_v;
    logic [13:0] r_pb_wr, r_pb_wg, r_pb_wb;
    logic [7:0]  r_pb_v8;
    always_ff @(posedge i_clk) begin
        logic [13:0] base;
        base  = 14'(8'd255 - r_pa_s2) * 14'd60;
        r_pb_wr <= 14'(base + 14'(r_pa_s2) * 14'(r_pa_fr));
        r_pb_wg <= 14'(base + 14'(r_pa_s2) * 14'(r_pa_fg));
        r_pb_wb <= 14'(base + 14'(r_pa_s2) * 14'(r_pa_fb));
        r_pb_v8 <= r_pa_v8;
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_pb_v <= 1'b0; else r_pb_v <= r_pa_v;
    end

    // stage c: products v*w, up to 255*15300
    logic        r_pc_v;
    logic [21:0] r_pc_pr, r_pc_pg, r_pc_pb;
    always_ff @(posedge i_clk) begin
        r_pc_pr <= 22'(r_pb_v8) * 22'(r_pb_wr);
        r_pc_pg <= 22'(r_pb_v8) * 22'(r_pb_wg);
        r_pc_pb <= 22'(r_pb_v8) * 22'(r_pb_wb);
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_pc_v <= 1'b0; else r_pc_v <= r_pb_v;
    end

    // stage d: divide by 15300 as reciprocal multiply, then one correction
    localparam int unsigned RecipSh = 36;
    localparam logic [22:0] Recip = 23'((64'd1 << RecipSh) / 64'd15300 + 64'd1);
    logic        r_pd_v;
    logic [8:0]  r_pd_qr, r_pd_qg, r_pd_qb;
    logic [21:0] r_pd_pr, r_pd_pg, r_pd_pb;
    always_ff @(posedge i_clk) begin
        logic [44:0] mr, mg, mb;
        mr = 45'(r_pc_pr) * 45'(Recip);
        mg = 45'(r_pc_pg) * 45'(Recip);
        mb = 45'(r_pc_pb) * 45'(Recip);
        r_pd_qr <= mr[44:36]; r_pd_qg <= mg[44:36]; r_pd_qb <= mb[44:36];
        r_pd_pr <= r_pc_pr; r_pd_pg <= r_pc_pg; r_pd_pb <= r_pc_pb;
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_pd_v <= 1'b0; else r_pd_v <= r_pc_v;
    end

    // stage e: quotient may be one high; fix by back-multiply
    function automatic logic [7:0] fixq(input logic [8:0] q, input logic [21:0] p);
        logic [23:0] bk;
        bk = 24'(q) * 24'd15300;
        if (bk > {2'd0, p}) return 8'(q - 9'd1);
        return q[7:0];
    endfunction
    logic       r_pe_v;
    logic [7:0] r_pe_r, r_pe_g, r_pe_b;
    always_ff @(posedge i_clk) begin
        r_pe_r <= fixq(r_pd_qr, r_pd_pr);
        r_pe_g <= fixq(r_pd_qg, r_pd_pg);
        r_pe_b <= fixq(r_pd_qb, r_pd_pb);
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_pe_v <= 1'b0; else r_pe_v <= r_pd_v;
    end

    assign o_done      = r_pe_v;
    assign o_red_out   = r_pe_r;
    assign o_green_out = r_pe_g;
    assign o_blue_out  = r_pe_b;

    `HSB_ASSERT_IMPL(a_never_busy, i_clk, i_rst_n, 1'b1, !busy)
    `HSB_ASSERT_IMPL(a_div_lockstep, i_clk, i_rst_n, sat_vld, hue_vld)
    `HSB_ASSERT_NEXT(a_done_from_e, i_clk, i_rst_n, r_pd_v, o_done)
endmodule

>>> design/hsb_divider.sv
// pipelined restoring divider: 17 bit numerator by 8 bit divisor, 3 quotient bits a stage
module hsb_divider #(
    parameter int unsigned TagW = hsb_pkg::PixW
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  logic [16:0]              i_num,
    input  logic [7:0]               i_den,
    input  logic [TagW-1:0]          i_tag,
    output logic                     o_valid,
    output logic [hsb_pkg::QuoW-1:0] o_quo,
    output logic [TagW-1:0]          o_tag
);
    localparam int unsigned Stages = hsb_pkg::NumW / hsb_pkg::DivSteps;
    hsb_pkg::t_div       r_st  [Stages];
    logic [TagW-1:0]     r_tag [Stages];
    logic [Stages-1:0]   r_vld;
    hsb_pkg::t_div       n_first;

    always_comb begin
        n_first.rem = '0;
        n_first.num = {1'b0, i_num};
        n_first.quo = '0;
        n_first.den = i_den;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[Stages-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_st[0]  <= hsb_pkg::div_steps(n_first);
        r_tag[0] <= i_tag;
        for (int s = 1; s < Stages; s++) begin
            r_st[s]  <= hsb_pkg::div_steps(r_st[s-1]);
            r_tag[s] <= r_tag[s-1];
        end
    end

    assign o_valid = r_vld[Stages-1];
    assign o_quo   = r_st[Stages-1].quo;
    assign o_tag   = r_tag[Stages-1];
endmodule
